// ===== hdl/fgfq_pkg.sv =====
// Shared constants, datapath command and status types for the gap-fit query block.
package fgfq_pkg;

  localparam int LINE_LEN = 65536;
  localparam int POS_W    = 16;
  localparam int VAL_W    = 16;
  localparam int NODE_W   = $clog2(2 * LINE_LEN);
  localparam int H_W      = NODE_W + 1;

  localparam logic FUNC_BUILD = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_RD_LEAF,
    OP_PRV_POS,
    OP_PRV_ZERO,
    OP_PRV_LEAF,
    OP_UP,
    OP_RD_LSIB,
    OP_TAKE_LSIB,
    OP_RD_RCH,
    OP_PD_EV,
    OP_SET_FIRST,
    OP_SET_NXT,
    OP_WR_LEAF,
    OP_RD_SIB,
    OP_WR_UP,
    OP_NXT_INIT,
    OP_RD_RSIB,
    OP_TAKE_RSIB,
    OP_RD_LCH,
    OP_ND_EV,
    OP_PFX_INIT,
    OP_PFX_ODD,
    OP_PFX_HALVE,
    OP_PFX_ACC,
    OP_FITS
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic rd_nz;
    logic idx_root;
    logic idx_odd;
    logic idx_leaf;
    logic h_done;
    logic h_odd;
    logic clr_done;
    logic pos_zero;
    logic is_query;
  } dp_stat_t;

  function automatic logic [VAL_W-1:0] vmax(input logic [VAL_W-1:0] a,
                                            input logic [VAL_W-1:0] b);
    vmax = (a > b) ? a : b;
  endfunction

endpackage

// ===== hdl/fgfq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fgfq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fgfq_dp.sv =====
// Datapath: gap max tree memory, walk registers and result register.
module fgfq_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  fgfq_pkg::dp_cmd_t            cmd,
  input  logic                         func,
  input  logic [fgfq_pkg::POS_W-1:0]   position,
  input  logic [fgfq_pkg::VAL_W-1:0]   block_size,
  output fgfq_pkg::dp_stat_t           stat,
  output logic                         fits
);

  localparam int NW = fgfq_pkg::NODE_W;
  localparam int HW = fgfq_pkg::H_W;
  localparam int PW = fgfq_pkg::POS_W;
  localparam int VW = fgfq_pkg::VAL_W;

  logic          func_q;
  logic [PW-1:0] pos_q;
  logic [VW-1:0] sz_q;
  logic [NW-1:0] idx;
  logic [HW-1:0] h;
  logic [NW-1:0] lb;
  logic [PW-1:0] prv;
  logic [PW-1:0] tgt;
  logic [VW-1:0] val;
  logic [VW-1:0] best;
  logic [NW-1:0] clr;

  logic          we;
  logic [NW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [NW-1:0] raddr;
  logic [VW-1:0] rdata;
  logic [VW-1:0] up_max;

  assign up_max = fgfq_pkg::vmax(val, rdata);

  fgfq_ram #(.WIDTH(VW), .DEPTH(2 * fgfq_pkg::LINE_LEN)) u_tree (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (cmd.op)
      fgfq_pkg::OP_RD_LEAF: raddr = {1'b1, pos_q};
      fgfq_pkg::OP_RD_LSIB: raddr = idx - NW'(1);
      fgfq_pkg::OP_RD_RCH:  raddr = {idx[NW-2:0], 1'b1};
      fgfq_pkg::OP_RD_SIB:  raddr = idx ^ NW'(1);
      fgfq_pkg::OP_RD_RSIB: raddr = idx + NW'(1);
      fgfq_pkg::OP_RD_LCH:  raddr = {idx[NW-2:0], 1'b0};
      fgfq_pkg::OP_PFX_ODD: raddr = h[NW-1:0] - NW'(1);
      fgfq_pkg::OP_CLR: begin
        we    = 1'b1;
        waddr = clr;
      end
      fgfq_pkg::OP_WR_LEAF: begin
        we    = 1'b1;
        waddr = {1'b1, tgt};
        wdata = val;
      end
      fgfq_pkg::OP_WR_UP: begin
        we    = 1'b1;
        waddr = idx >> 1;
        wdata = up_max;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.rd_nz    = (rdata != '0);
    stat.idx_root = (idx == NW'(1));
    stat.idx_odd  = idx[0];
    stat.idx_leaf = idx[NW-1];
    stat.h_done   = (h <= {1'b0, lb});
    // lower bound odd only at the root level: a full prefix takes the root there
    stat.h_odd    = h[0] | lb[0];
    stat.clr_done = &clr;
    stat.pos_zero = (pos_q == '0);
    stat.is_query = (func_q == fgfq_pkg::FUNC_QUERY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
    end else if (cmd.op == fgfq_pkg::OP_CLR) begin
      clr <= clr + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fgfq_pkg::OP_LOAD: begin
        func_q <= func;
        pos_q  <= position;
        sz_q   <= block_size;
      end
      fgfq_pkg::OP_RD_LEAF:   idx <= {1'b1, pos_q};
      fgfq_pkg::OP_PRV_POS:   prv <= pos_q;
      fgfq_pkg::OP_PRV_ZERO:  prv <= '0;
      fgfq_pkg::OP_PRV_LEAF:  prv <= idx[PW-1:0];
      fgfq_pkg::OP_UP:        idx <= idx >> 1;
      fgfq_pkg::OP_TAKE_LSIB: idx <= idx - NW'(1);
      fgfq_pkg::OP_TAKE_RSIB: idx <= idx + NW'(1);
      fgfq_pkg::OP_PD_EV:     idx <= {idx[NW-2:0], rdata != '0};
      fgfq_pkg::OP_ND_EV:     idx <= {idx[NW-2:0], rdata == '0};
      fgfq_pkg::OP_SET_FIRST: begin
        tgt <= pos_q;
        val <= pos_q - prv;
      end
      fgfq_pkg::OP_SET_NXT: begin
        tgt <= idx[PW-1:0];
        val <= idx[PW-1:0] - pos_q;
      end
      fgfq_pkg::OP_WR_LEAF:   idx <= {1'b1, tgt};
      fgfq_pkg::OP_WR_UP: begin
        val <= up_max;
        idx <= idx >> 1;
      end
      fgfq_pkg::OP_NXT_INIT:  idx <= {1'b1, pos_q};
      fgfq_pkg::OP_PFX_INIT: begin
        h    <= HW'(fgfq_pkg::LINE_LEN) + HW'(prv) + HW'(1);
        lb   <= NW'(fgfq_pkg::LINE_LEN);
        best <= '0;
      end
      fgfq_pkg::OP_PFX_ODD:   h <= h - HW'(1);
      fgfq_pkg::OP_PFX_HALVE: begin
        h  <= h >> 1;
        lb <= lb >> 1;
      end
      fgfq_pkg::OP_PFX_ACC: begin
        best <= fgfq_pkg::vmax(best, rdata);
        h    <= h >> 1;
        lb   <= lb >> 1;
      end
      fgfq_pkg::OP_FITS:      fits <= (best >= sz_q) || ((pos_q - prv) >= sz_q);
      default: ;
    endcase
  end

endmodule

// ===== hdl/fgfq_ctrl.sv =====
// Controller: sequences clearing, neighbour searches, tree updates and prefix max.
module fgfq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  fgfq_pkg::dp_stat_t  stat,
  output fgfq_pkg::dp_cmd_t   cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_LEAF_EV, S_PU, S_PU_EV, S_PD, S_PD_EV,
    S_FOUND, S_SET_W, S_SU, S_SU_EV, S_NU, S_NU_EV, S_ND, S_ND_EV,
    S_QP, S_QP_EV, S_OUT
  } state_t;

  state_t state, state_next;
  logic   second, second_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    second_next    = second;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = fgfq_pkg::OP_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = fgfq_pkg::OP_CLR;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = fgfq_pkg::OP_LOAD;
          state_next = S_START;
        end
      end
      S_START: begin
        if (stat.pos_zero) begin
          if (stat.is_query) begin
            cmd.op     = fgfq_pkg::OP_PRV_ZERO;
            state_next = S_FOUND;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = fgfq_pkg::OP_RD_LEAF;
          state_next = S_LEAF_EV;
        end
      end
      S_LEAF_EV: begin
        // non-zero leaf means an obstacle already stands there
        if (stat.rd_nz) begin
          if (stat.is_query) begin
            cmd.op     = fgfq_pkg::OP_PRV_POS;
            state_next = S_FOUND;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_PU;
        end
      end
      S_PU: begin
        if (stat.idx_root) begin
          cmd.op     = fgfq_pkg::OP_PRV_ZERO;
          state_next = S_FOUND;
        end else if (stat.idx_odd) begin
          cmd.op     = fgfq_pkg::OP_RD_LSIB;
          state_next = S_PU_EV;
        end else begin
          cmd.op = fgfq_pkg::OP_UP;
        end
      end
      S_PU_EV: begin
        if (stat.rd_nz) begin
          cmd.op     = fgfq_pkg::OP_TAKE_LSIB;
          state_next = S_PD;
        end else begin
          cmd.op     = fgfq_pkg::OP_UP;
          state_next = S_PU;
        end
      end
      S_PD: begin
        if (stat.idx_leaf) begin
          cmd.op     = fgfq_pkg::OP_PRV_LEAF;
          state_next = S_FOUND;
        end else begin
          cmd.op     = fgfq_pkg::OP_RD_RCH;
          state_next = S_PD_EV;
        end
      end
      S_PD_EV: begin
        cmd.op     = fgfq_pkg::OP_PD_EV;
        state_next = S_PD;
      end
      S_FOUND: begin
        if (stat.is_query) begin
          cmd.op     = fgfq_pkg::OP_PFX_INIT;
          state_next = S_QP;
        end else begin
          cmd.op      = fgfq_pkg::OP_SET_FIRST;
          second_next = 1'b0;
          state_next  = S_SET_W;
        end
      end
      S_SET_W: begin
        cmd.op     = fgfq_pkg::OP_WR_LEAF;
        state_next = S_SU;
      end
      S_SU: begin
        if (stat.idx_root) begin
          if (second) begin
            state_next = S_IDLE;
          end else begin
            cmd.op     = fgfq_pkg::OP_NXT_INIT;
            state_next = S_NU;
          end
        end else begin
          cmd.op     = fgfq_pkg::OP_RD_SIB;
          state_next = S_SU_EV;
        end
      end
      S_SU_EV: begin
        cmd.op     = fgfq_pkg::OP_WR_UP;
        state_next = S_SU;
      end
      S_NU: begin
        if (stat.idx_root) begin
          state_next = S_IDLE;
        end else if (!stat.idx_odd) begin
          cmd.op     = fgfq_pkg::OP_RD_RSIB;
          state_next = S_NU_EV;
        end else begin
          cmd.op = fgfq_pkg::OP_UP;
        end
      end
      S_NU_EV: begin
        if (stat.rd_nz) begin
          cmd.op     = fgfq_pkg::OP_TAKE_RSIB;
          state_next = S_ND;
        end else begin
          cmd.op     = fgfq_pkg::OP_UP;
          state_next = S_NU;
        end
      end
      S_ND: begin
        if (stat.idx_leaf) begin
          cmd.op      = fgfq_pkg::OP_SET_NXT;
          second_next = 1'b1;
          state_next  = S_SET_W;
        end else begin
          cmd.op     = fgfq_pkg::OP_RD_LCH;
          state_next = S_ND_EV;
        end
      end
      S_ND_EV: begin
        cmd.op     = fgfq_pkg::OP_ND_EV;
        state_next = S_ND;
      end
      S_QP: begin
        if (stat.h_done) begin
          state_next = S_OUT;
        end else if (stat.h_odd) begin
          cmd.op     = fgfq_pkg::OP_PFX_ODD;
          state_next = S_QP_EV;
        end else begin
          cmd.op = fgfq_pkg::OP_PFX_HALVE;
        end
      end
      S_QP_EV: begin
        cmd.op     = fgfq_pkg::OP_PFX_ACC;
        state_next = S_QP;
      end
      S_OUT: begin
        // hold until the previous result has left the output register
        if (!out_valid || out_ready) begin
          cmd.op         = fgfq_pkg::OP_FITS;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      second    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      second    <= second_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== hdl/free_gap_fit_query.sv =====
// Top level of the obstacle line gap-fit query block.
//
// Input channel (in_valid/in_ready) carries func, position, block_size.
// func 0 builds an obstacle at position (no result); func 1 asks whether a
// block of block_size fits in [0, position]; each query gives one fits result
// on the output channel (out_valid/out_ready).
// Gaps live in a 131072-entry max tree in one RAM; the walk steps that look at a
// node read that RAM, while plain steps up or halving steps read nothing.
// Query: previous-obstacle search, then prefix max.
// Build: previous search, a leaf-to-root update, a next-obstacle search and,
// if a next obstacle is found, a second update; duplicates end early.
// One request is in work at a time; in_ready is high only when idle.
// After reset a clearing pass writes every tree entry, with in_ready low. A
// result waits in the output register while the receiver stalls; the next
// request is still taken, but its result is held back until the pending one
// has been taken.
module free_gap_fit_query (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       func,
  input  logic [fgfq_pkg::POS_W-1:0] position,
  input  logic [fgfq_pkg::VAL_W-1:0] block_size,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       fits
);

  fgfq_pkg::dp_cmd_t  cmd;
  fgfq_pkg::dp_stat_t stat;

  fgfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fgfq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (func),
    .position   (position),
    .block_size (block_size),
    .stat       (stat),
    .fits       (fits)
  );

  // reset starts the clearing pass: nothing taken, nothing offered
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!in_ready && !out_valid))
    else $error("request taken or result offered right after reset");

  // a result only appears while a request is in work
  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised while idle");

  // a build produces no result: out_valid stays low right after a build is taken while none is pending
  a_build_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (func == fgfq_pkg::FUNC_BUILD) && !out_valid) |=> !out_valid)
    else $error("result raised after a build request");

endmodule
